// ===== rtl/display_dirty_segment_finder_top_defines.svh =====
// Assertion macros used by the dirty segment finder back end.
`ifndef DISPLAY_DIRTY_SEGMENT_FINDER_TOP_DEFINES_SVH
`define DISPLAY_DIRTY_SEGMENT_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define DDSF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define DDSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ddsf_pkg.sv =====
// Package: constants and types of the display dirty segment finder.
`default_nettype none

package ddsf_pkg;

  // Frame geometry defaults
  localparam int unsigned PAGES_DEF   = 8;
  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Counter widths that cover the full geometry range
  localparam int unsigned PAGE_CNT_W = 4;
  localparam int unsigned COL_CNT_W  = 7;

  // Field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned GAP_LIMIT_W = 10;
  localparam int unsigned SEG_PAGE_W  = 3;
  localparam int unsigned SEG_COL_W   = 7;
  localparam int unsigned SEG_LEN_W   = 11;
  localparam int unsigned PAGE_CMD_W  = 8;
  localparam int unsigned COL_LO_W    = 4;
  localparam int unsigned COL_HI_W    = 5;
  localparam int unsigned OUT_DATA_W  = 40;

  // Command encodings
  localparam logic [PAGE_CMD_W-1:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [COL_HI_W-1:0]   COL_HI_BASE   = 5'h10;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_FULL = 2'd1;

  // Reset values of the registers
  localparam logic [GAP_LIMIT_W-1:0] GAP_LIMIT_RST = 10'd4;

  // One classified item passed from front to back
  typedef struct packed {
    logic                  changed;
    logic                  last;
    logic [PAGE_CNT_W-1:0] page;
    logic [COL_CNT_W-1:0]  col;
  } ddsf_item_t;

  // One finished segment
  typedef struct packed {
    logic [COL_HI_W-1:0]   col_high_cmd;
    logic [COL_LO_W-1:0]   col_low_cmd;
    logic [PAGE_CMD_W-1:0] page_cmd;
    logic [SEG_LEN_W-1:0]  seg_length;
    logic [SEG_COL_W-1:0]  seg_column;
    logic [SEG_PAGE_W-1:0] seg_page;
  } ddsf_seg_t;

endpackage

`default_nettype wire

// ===== rtl/display_dirty_segment_finder_top.sv =====
// Top level of the display dirty segment finder.
`default_nettype none

// Frame bytes stream in page-major raster order, one item per clock, and each is
// compared with the byte last sent at the same position, which is then replaced.
// Runs of changed bytes, joined across unchanged gaps of at most gap_limit bytes,
// come out as segments with start page, column, length and the three set-position
// command bytes. An accepted item is registered in the compare stage, then pushed
// into the item queue; a segment it closes is registered in the result register.
// Throughput is one item per cycle while the queue has room, set by the single
// read-first port of the frame store, which is read and written in the accept
// cycle. A result waiting on the output does not stop input until the four-entry
// item queue and the compare stage in front of it fill. The stored frame reads as
// all zero during the first frame after reset (a frame-done flag stands in for
// clearing), so no clearing pass is needed and the block is ready right out of
// reset. Configuration writes are always accepted; write them only while the block
// is idle.
module display_dirty_segment_finder_top #(
  parameter int unsigned PAGES       = ddsf_pkg::PAGES_DEF,
  parameter int unsigned COLUMNS     = ddsf_pkg::COLUMNS_DEF,
  parameter int unsigned QUEUE_DEPTH = ddsf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ddsf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ddsf_pkg::GAP_LIMIT_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [ddsf_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] new_byte
  // output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [2:0] seg_page, [9:3] seg_column, [20:10] seg_length, [28:21] page_cmd,
  // [32:29] col_low_cmd, [37:33] col_high_cmd, [39:38] zero
  output logic [ddsf_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
  import ddsf_pkg::*;

  logic [GAP_LIMIT_W-1:0] gap_limit_q, gap_limit_d;
  logic                   force_full_q, force_full_d;
  logic                   cfg_write;

  ddsf_item_t front_item;
  ddsf_item_t queue_item;
  logic       front_valid;
  logic       queue_full;
  logic       queue_empty;
  logic       queue_pop;
  ddsf_seg_t  seg;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    gap_limit_d  = gap_limit_q;
    force_full_d = force_full_q;
    if (cfg_write) begin
      case (cfg_index_i)
        CFG_GAP_LIMIT:  gap_limit_d  = cfg_data_i;
        CFG_FORCE_FULL: force_full_d = cfg_data_i[0];
        default: begin
          gap_limit_d  = gap_limit_q;
          force_full_d = force_full_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q  <= GAP_LIMIT_RST;
      force_full_q <= 1'b0;
    end else begin
      gap_limit_q  <= gap_limit_d;
      force_full_q <= force_full_d;
    end
  end

  ddsf_front #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .force_full_i (force_full_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .item_valid_o (front_valid),
    .item_full_i  (queue_full),
    .item_o       (front_item)
  );

  ddsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .item_o  (queue_item),
    .empty_o (queue_empty)
  );

  ddsf_back #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gap_limit_i  (gap_limit_q),
    .item_empty_i (queue_empty),
    .item_pop_o   (queue_pop),
    .item_i       (queue_item),
    .seg_valid_o  (m_axis_tvalid),
    .seg_ready_i  (m_axis_tready),
    .seg_o        (seg)
  );

  assign m_axis_tdata = OUT_DATA_W'(seg);

endmodule

`default_nettype wire

// ===== rtl/ddsf_front.sv =====
// Front end: takes frame bytes, compares them with the stored frame, classifies.
`default_nettype none

module ddsf_front #(
  parameter int unsigned PAGES   = ddsf_pkg::PAGES_DEF,
  parameter int unsigned COLUMNS = ddsf_pkg::COLUMNS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        force_full_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ddsf_pkg::BYTE_W-1:0] in_byte_i,
  output logic                             item_valid_o,
  input  wire logic                        item_full_i,
  output ddsf_pkg::ddsf_item_t             item_o
);
  import ddsf_pkg::*;

  localparam int unsigned FRAME  = PAGES * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(FRAME);

  // Stored frame, read-first single port
  logic [BYTE_W-1:0] frame_mem [FRAME];

  logic                  accept;
  logic                  advance;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [PAGE_CNT_W-1:0] page_q, page_d;
  logic [COL_CNT_W-1:0]  col_q, col_d;
  logic                  last_pos;
  logic                  filled_q, filled_d;

  logic                  st_valid_q, st_valid_d;
  logic [BYTE_W-1:0]     st_byte_q;
  logic [BYTE_W-1:0]     st_old_q;
  logic                  st_fresh_q;
  logic                  st_last_q;
  logic [PAGE_CNT_W-1:0] st_page_q;
  logic [COL_CNT_W-1:0]  st_col_q;
  logic [BYTE_W-1:0]     old_byte;

  assign advance    = !st_valid_q || !item_full_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;
  assign last_pos   = (addr_q == ADDR_W'(FRAME - 1));

  // Raster position counters
  always_comb begin
    addr_d   = addr_q;
    page_d   = page_q;
    col_d    = col_q;
    filled_d = filled_q;
    if (accept) begin
      if (last_pos) begin
        addr_d   = '0;
        page_d   = '0;
        col_d    = '0;
        filled_d = 1'b1;
      end else begin
        addr_d = addr_q + ADDR_W'(1);
        if (col_q == COL_CNT_W'(COLUMNS - 1)) begin
          col_d  = '0;
          page_d = page_q + PAGE_CNT_W'(1);
        end else begin
          col_d = col_q + COL_CNT_W'(1);
        end
      end
    end
  end

  assign st_valid_d = accept ? 1'b1 : (advance ? 1'b0 : st_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      page_q     <= '0;
      col_q      <= '0;
      filled_q   <= 1'b0;
      st_valid_q <= 1'b0;
    end else begin
      addr_q     <= addr_d;
      page_q     <= page_d;
      col_q      <= col_d;
      filled_q   <= filled_d;
      st_valid_q <= st_valid_d;
    end
  end

  // Frame store access and compare stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_old_q          <= frame_mem[addr_q];
      frame_mem[addr_q] <= in_byte_i;
      st_byte_q         <= in_byte_i;
      st_fresh_q        <= !filled_q;
      st_last_q         <= last_pos;
      st_page_q         <= page_q;
      st_col_q          <= col_q;
    end
  end

  // Nothing written yet in the first frame after reset: old data reads as zero
  assign old_byte = st_fresh_q ? '0 : st_old_q;

  always_comb begin
    item_o.changed = force_full_i || (old_byte != st_byte_q);
    item_o.last    = st_last_q;
    item_o.page    = st_page_q;
    item_o.col     = st_col_q;
  end

  assign item_valid_o = st_valid_q;

endmodule

`default_nettype wire

// ===== rtl/ddsf_queue.sv =====
// Short queue of classified items between front and back.
`default_nettype none

module ddsf_queue #(
  parameter int unsigned DEPTH = ddsf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ddsf_pkg::ddsf_item_t item_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output ddsf_pkg::ddsf_item_t      item_o,
  output logic                      empty_o
);
  import ddsf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ddsf_item_t       slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slots_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ddsf_back.sv =====
// Back end: segment tracking, gap merging and result register.
`default_nettype none
`include "display_dirty_segment_finder_top_defines.svh"

module ddsf_back #(
  parameter int unsigned PAGES   = ddsf_pkg::PAGES_DEF,
  parameter int unsigned COLUMNS = ddsf_pkg::COLUMNS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [ddsf_pkg::GAP_LIMIT_W-1:0] gap_limit_i,
  input  wire logic                             item_empty_i,
  output logic                                  item_pop_o,
  input  wire ddsf_pkg::ddsf_item_t             item_i,
  output logic                                  seg_valid_o,
  input  wire logic                             seg_ready_i,
  output ddsf_pkg::ddsf_seg_t                   seg_o
);
  import ddsf_pkg::*;

  localparam int unsigned FRAME = PAGES * COLUMNS;
  localparam int unsigned LEN_W = $clog2(FRAME + 1);
  localparam int unsigned CMP_W = (LEN_W > GAP_LIMIT_W) ? LEN_W : GAP_LIMIT_W;

  logic                  open_q, open_d;
  logic [PAGE_CNT_W-1:0] start_page_q, start_page_d;
  logic [COL_CNT_W-1:0]  start_col_q, start_col_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [LEN_W-1:0]      gap_q, gap_d;
  logic                  emit;
  logic                  out_free;
  logic                  out_valid_q, out_valid_d;
  ddsf_seg_t             out_q, out_d;

  assign out_free   = !out_valid_q || seg_ready_i;
  assign item_pop_o = !item_empty_i && out_free;

  // Segment state update for one item
  always_comb begin
    open_d       = open_q;
    start_page_d = start_page_q;
    start_col_d  = start_col_q;
    len_d        = len_q;
    gap_d        = gap_q;
    emit         = 1'b0;
    if (item_pop_o) begin
      if (item_i.changed) begin
        if (!open_q) begin
          open_d       = 1'b1;
          start_page_d = item_i.page;
          start_col_d  = item_i.col;
          len_d        = LEN_W'(1);
        end else begin
          len_d = len_q + gap_q + LEN_W'(1);
        end
        gap_d = '0;
      end else if (open_q) begin
        gap_d = gap_q + LEN_W'(1);
        // gap too long: close the segment here
        if (CMP_W'(gap_d) > CMP_W'(gap_limit_i)) begin
          emit   = 1'b1;
          open_d = 1'b0;
          gap_d  = '0;
        end
      end
      // frame end closes whatever is open
      if (item_i.last) begin
        if (open_d) begin
          emit = 1'b1;
        end
        open_d = 1'b0;
        gap_d  = '0;
      end
    end
  end

  // Result fields
  always_comb begin
    out_d.seg_page     = start_page_d[SEG_PAGE_W-1:0];
    out_d.seg_column   = SEG_COL_W'(start_col_d);
    out_d.seg_length   = SEG_LEN_W'(len_d);
    out_d.page_cmd     = PAGE_CMD_BASE + PAGE_CMD_W'(start_page_d);
    out_d.col_low_cmd  = start_col_d[COL_LO_W-1:0];
    out_d.col_high_cmd = COL_HI_BASE | COL_HI_W'(start_col_d[6:4]);
  end

  assign out_valid_d = emit ? 1'b1 : (seg_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      start_page_q <= '0;
      start_col_q  <= '0;
      len_q        <= '0;
      gap_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      open_q       <= open_d;
      start_page_q <= start_page_d;
      start_col_q  <= start_col_d;
      len_q        <= len_d;
      gap_q        <= gap_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign seg_valid_o = out_valid_q;
  assign seg_o       = out_q;

  // Gap counting only runs inside an open segment
  `DDSF_ASSERT_IMPLY(a_gap_needs_open, gap_q != '0, open_q, "gap counted with no open segment")
  // A frame end never leaves a segment open
  `DDSF_ASSERT_NEXT(a_last_closes, item_pop_o && item_i.last, !open_q && gap_q == '0,
                    "segment open after frame end")
  // Every reported segment carries at least one byte
  `DDSF_ASSERT_NEXT(a_len_nonzero, emit, seg_valid_o && len_q != '0,
                    "empty segment reported")

endmodule

`default_nettype wire
